// ===== rtl/core/omsc_pkg.sv =====
// omsc_pkg: shared widths, codes, payload and control types for the online mean/stddev core
// used by every module under rtl/core; depends on nothing
`timescale 1ns / 1ps

package omsc_pkg;

  localparam int COUNT_BITS    = 24;
  localparam int SAMPLE_BITS   = 32;
  localparam int CFG_BITS      = 24;
  localparam int MODE_BITS     = 2;
  localparam int CFG_ADDR_BITS = 2;
  localparam int SUM_BITS      = 64;
  localparam int DIV_BITS      = 64;
  localparam int DVS_BITS      = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
  localparam int ITER_BITS     = $clog2(DIV_BITS + 1);
  localparam int ROOT_BITS     = SUM_BITS / 2;
  localparam int DELTA_BITS    = SAMPLE_BITS + 1;
  localparam int PROD_BITS     = 2 * DELTA_BITS;
  localparam int PCT_BITS      = 7;
  localparam int PCT_N         = 8;
  localparam int PCT_IDX_BITS  = $clog2(PCT_N);

  localparam logic [CFG_BITS-1:0]  TOTAL_RST    = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0]  INTERVAL_RST = CFG_BITS'(100);

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_TOTAL    = 2'd0,
    REG_MODE     = 2'd1,
    REG_INTERVAL = 2'd2
  } reg_idx_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_NONE     = 2'd0,
    MODE_INTERVAL = 2'd1,
    MODE_SMART    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    DIV_MEAN = 2'd0,
    DIV_MOD  = 2'd1,
    DIV_SD   = 2'd2
  } div_op_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          sample_invalid;
  } in_t;

  typedef struct packed {
    logic                          record_kind;
    logic [COUNT_BITS-1:0]         sample_count;
    logic [COUNT_BITS-1:0]         valid_count;
    logic signed [SAMPLE_BITS-1:0] mean_value;
    logic [SAMPLE_BITS-1:0]        std_deviation;
    logic signed [SAMPLE_BITS-1:0] minimum;
    logic signed [SAMPLE_BITS-1:0] maximum;
    logic                          no_valid;
    logic                          last_result;
  } out_t;

  typedef struct packed {
    logic    load;
    logic    div_start;
    div_op_t div_op;
    logic    mean_upd;
    logic    mul_start;
    logic    acc_upd;
    logic    sched;
    logic    pct_step;
    logic    mod_done;
    logic    sqrt_start;
    logic    sd_ld;
    logic    sd_zero;
    logic    emit_cp;
    logic    emit_fin;
  } cmd_t;

  typedef struct packed {
    logic sample_ok;
    logic n_zero;
    logic div_done;
    logic mul_done;
    logic sqrt_done;
    logic smart;
    logic mod_need;
    logic pct_last;
    logic hit;
    logic final_rec;
    logic multi_valid;
    logic out_taken;
  } stat_t;

  // percent points of the smart schedule
  function automatic logic [PCT_BITS-1:0] pct_value(input logic [PCT_IDX_BITS-1:0] idx);
    logic [PCT_BITS-1:0] p;
    case (idx)
      3'd0:    p = 7'd1;
      3'd1:    p = 7'd5;
      3'd2:    p = 7'd10;
      3'd3:    p = 7'd25;
      3'd4:    p = 7'd50;
      3'd5:    p = 7'd75;
      3'd6:    p = 7'd90;
      default: p = 7'd95;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/online_mean_stddev_checkpoints_core.sv =====
// online_mean_stddev_checkpoints_core: top level joining sequencer and datapath
// depends on omsc_pkg, omsc_ctrl, omsc_dp (which holds omsc_div and omsc_sqrt)
`timescale 1ns / 1ps

// Takes one Q16.16 sample per transaction, keeps a Welford running mean, a saturating
// squared-deviation sum and min/max, and emits checkpoint and end-of-run records on
// the out channel. One transaction is handled at a time: an invalid sample skips the
// divider and multiplier, a valid one passes the bit-serial divider and the shift-add
// multiplier; smart mode steps the percent points, interval mode runs a modulo
// division, and a record adds divider, square-root and emit steps before the out
// handshake. in_ready is low until the last record of the transaction is taken.
module online_mean_stddev_checkpoints_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [omsc_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [omsc_pkg::CFG_BITS-1:0]        cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  omsc_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output omsc_pkg::out_t                       out_data
);

  omsc_pkg::cmd_t  cmd;
  omsc_pkg::stat_t stat;

  omsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  omsc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // no new transaction while a record is pending
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while a record is pending");

  a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.record_kind) |-> out_data.last_result)
    else $error("summary record not marked last");

  a_checkpoint_extremes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.record_kind) |->
      (out_data.minimum == '0 && out_data.maximum == '0))
    else $error("checkpoint carries extremes");

  a_no_valid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.no_valid) |->
      (out_data.mean_value == '0 && out_data.std_deviation == '0 &&
       out_data.valid_count == '0))
    else $error("empty run record has statistics");

endmodule

// ===== rtl/core/omsc_div.sv =====
// omsc_div: restoring divider, one quotient bit per cycle, dividend left-aligned
// depends on omsc_pkg for widths
`timescale 1ns / 1ps

module omsc_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [omsc_pkg::DIV_BITS-1:0]       dividend,
  input  logic [omsc_pkg::DVS_BITS-1:0]       divisor,
  input  logic [omsc_pkg::ITER_BITS-1:0]      iters,
  output logic [omsc_pkg::DIV_BITS-1:0]       quotient,
  output logic [omsc_pkg::DVS_BITS-1:0]       remainder,
  output logic                                done
);

  localparam int DW = omsc_pkg::DIV_BITS;
  localparam int VW = omsc_pkg::DVS_BITS;

  logic [DW-1:0]                    quo_r, quo_nxt;
  logic [VW-1:0]                    rem_r, rem_nxt;
  logic [VW-1:0]                    dvs_r;
  logic [omsc_pkg::ITER_BITS-1:0]   cnt_r;
  logic                             busy_r;
  logic                             done_r;
  logic [VW:0]                      trial;
  logic [VW:0]                      diff;

  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    diff  = trial - {1'b0, dvs_r};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = diff[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == omsc_pkg::ITER_BITS'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == omsc_pkg::ITER_BITS'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

// ===== rtl/core/omsc_sqrt.sv =====
// omsc_sqrt: bit-pair floor square root, one result bit per cycle
// depends on omsc_pkg for widths
`timescale 1ns / 1ps

module omsc_sqrt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [omsc_pkg::SUM_BITS-1:0]      radicand,
  output logic [omsc_pkg::ROOT_BITS-1:0]     root,
  output logic                               done
);

  localparam int XW = omsc_pkg::SUM_BITS;
  localparam int RW = omsc_pkg::ROOT_BITS;
  localparam int CW = $clog2(RW + 1);

  logic [XW-1:0]   x_r;
  logic [RW+1:0]   rem_r;
  logic [RW-1:0]   root_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [RW+1:0]   r2;
  logic [RW+1:0]   trial;

  always_comb begin
    r2    = {rem_r[RW-1:0], x_r[XW-1:XW-2]};
    trial = {root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r <= {x_r[XW-3:0], 2'b00};
      if (r2 >= trial) begin
        rem_r  <= r2 - trial;
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= r2;
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

// ===== rtl/core/omsc_dp.sv =====
// omsc_dp: datapath with config and run registers, shift-add multiplier, schedule
// checks and the output register; uses omsc_pkg, omsc_div and omsc_sqrt
`timescale 1ns / 1ps

module omsc_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [omsc_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [omsc_pkg::CFG_BITS-1:0]        cfg_wdata,
  input  omsc_pkg::in_t                        in_data,
  input  omsc_pkg::cmd_t                       cmd,
  output omsc_pkg::stat_t                      stat,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output omsc_pkg::out_t                       out_data
);

  localparam int C   = omsc_pkg::COUNT_BITS;
  localparam int S   = omsc_pkg::SAMPLE_BITS;
  localparam int D   = omsc_pkg::DELTA_BITS;
  localparam int PW  = omsc_pkg::PROD_BITS;
  localparam int PX  = (PW > 65) ? PW : 65;
  localparam int SW  = omsc_pkg::SUM_BITS;
  localparam int DW  = omsc_pkg::DIV_BITS;
  localparam int VW  = omsc_pkg::DVS_BITS;
  localparam int LW  = (C > omsc_pkg::CFG_BITS) ? C : omsc_pkg::CFG_BITS;
  localparam int QW  = C + omsc_pkg::PCT_BITS + 1;
  localparam int MCW = $clog2(D + 1);

  // configuration
  logic [omsc_pkg::CFG_BITS-1:0]   total_r;
  logic [omsc_pkg::MODE_BITS-1:0]  mode_r;
  logic [omsc_pkg::CFG_BITS-1:0]   interval_r;

  // run state
  logic [C-1:0]          cnt_r;
  logic [C-1:0]          vcnt_r;
  logic signed [S-1:0]   mean_r;
  logic [SW-1:0]         sum_r;
  logic signed [S-1:0]   min_r;
  logic signed [S-1:0]   max_r;
  logic [C-1:0]          pow_r;

  // per transaction
  logic                  ok_r;
  logic signed [S-1:0]   v_r;
  logic signed [D-1:0]   delta_r;
  logic [D-1:0]          mul_a_r;
  logic [PW-1:0]         p_r;
  logic [MCW-1:0]        mcnt_r;
  logic                  mbusy_r;
  logic                  mdone_r;
  logic                  hit_r;
  logic                  final_r;
  logic [omsc_pkg::PCT_IDX_BITS-1:0] pidx_r;
  logic [S-1:0]          sd_r;
  logic                  out_valid_r;
  omsc_pkg::out_t        out_data_r;

  logic [C-1:0]          limit;
  logic [LW-1:0]         total_w;
  logic [LW-1:0]         cmax_w;
  logic signed [S-1:0]   smp;
  logic signed [D-1:0]   delta_in;
  logic [D-1:0]          abs_delta;
  logic signed [S+1:0]   q_signed;
  logic signed [S+1:0]   mean_sum;
  logic signed [S-1:0]   mean_new;
  logic signed [D-1:0]   delta2;
  logic [D-1:0]          abs_delta2;
  logic [D:0]            mul_upper;
  logic [PX-1:0]         p_ext;
  logic [SW-1:0]         prod_sat;
  logic [SW:0]           sum_add;
  logic [C+3:0]          pow_x10;
  logic [QW-1:0]         pct_x;
  logic [QW-1:0]         pct_y;
  logic                  pct_hit;
  logic [DW-1:0]         div_dividend;
  logic [VW-1:0]         div_divisor;
  logic [omsc_pkg::ITER_BITS-1:0] div_iters;
  logic [DW-1:0]         div_quo;
  logic [VW-1:0]         div_rem;
  logic                  div_done;
  logic [omsc_pkg::ROOT_BITS-1:0] sq_root;
  logic                  sq_done;
  logic                  none;
  logic                  sched_hit;
  logic                  final_now;
  omsc_pkg::out_t        rec;

  always_comb begin
    total_w = LW'(total_r);
    cmax_w  = LW'({C{1'b1}});
    limit   = (total_w > cmax_w) ? C'(cmax_w) : C'(total_w);
  end

  // sample, deltas and magnitudes
  always_comb begin
    smp        = in_data.sample_value;
    delta_in   = D'(smp) - D'(mean_r);
    abs_delta  = delta_r[D-1] ? D'(-delta_r) : D'(delta_r);
    q_signed   = (S+2)'($signed({1'b0, div_quo[D-1:0]}));
    if (delta_r[D-1]) begin
      q_signed = -q_signed;
    end
    if (vcnt_r == '0) begin
      q_signed = '0;
    end
    mean_sum   = (S+2)'(mean_r) + q_signed;
    mean_new   = S'(mean_sum);
    delta2     = D'(v_r) - D'(mean_r);
    abs_delta2 = delta2[D-1] ? D'(-delta2) : D'(delta2);
  end

  // multiplier step and saturation of the product and the sum
  always_comb begin
    mul_upper = {1'b0, p_r[PW-1:D]} + (p_r[0] ? {1'b0, mul_a_r} : '0);
    p_ext     = PX'(p_r);
    prod_sat  = (|p_ext[PX-1:SW]) ? '1 : p_ext[SW-1:0];
    sum_add   = {1'b0, sum_r} + {1'b0, prod_sat};
  end

  // schedule checks
  always_comb begin
    pow_x10   = {pow_r, 3'b000} + {2'b00, pow_r, 1'b0};
    final_now = (cnt_r >= limit);
    sched_hit = 1'b0;
    if (mode_r == omsc_pkg::MODE_INTERVAL) begin
      sched_hit = (cnt_r == limit);
    end else if (mode_r == omsc_pkg::MODE_SMART) begin
      sched_hit = (cnt_r == limit) || ((cnt_r == pow_r) && (cnt_r < limit));
    end
    // c equals floor(limit*p/100) when 100c <= limit*p < 100c+100
    pct_x   = QW'(limit) * QW'(omsc_pkg::pct_value(pidx_r));
    pct_y   = QW'(cnt_r) * QW'(100);
    pct_hit = (cnt_r != '0) && (pct_x >= pct_y) && (pct_x < pct_y + QW'(100));
  end

  // divider operand select
  always_comb begin
    case (cmd.div_op)
      omsc_pkg::DIV_MEAN: begin
        div_dividend = {abs_delta, {(DW-D){1'b0}}};
        div_divisor  = VW'(vcnt_r);
        div_iters    = omsc_pkg::ITER_BITS'(D);
      end
      omsc_pkg::DIV_MOD: begin
        div_dividend = {cnt_r, {(DW-C){1'b0}}};
        div_divisor  = VW'(interval_r);
        div_iters    = omsc_pkg::ITER_BITS'(C);
      end
      default: begin
        div_dividend = DW'(sum_r);
        div_divisor  = VW'(vcnt_r - 1'b1);
        div_iters    = omsc_pkg::ITER_BITS'(DW);
      end
    endcase
  end

  omsc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .iters     (div_iters),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  omsc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (SW'(div_quo)),
    .root     (sq_root),
    .done     (sq_done)
  );

  // result record from the current run state
  always_comb begin
    none               = (vcnt_r == '0);
    rec.record_kind    = cmd.emit_fin;
    rec.sample_count   = cnt_r;
    rec.valid_count    = vcnt_r;
    rec.mean_value     = none ? '0 : mean_r;
    rec.std_deviation  = none ? '0 : sd_r;
    rec.minimum        = (none || !cmd.emit_fin) ? '0 : min_r;
    rec.maximum        = (none || !cmd.emit_fin) ? '0 : max_r;
    rec.no_valid       = none;
    rec.last_result    = cmd.emit_fin || !final_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= omsc_pkg::TOTAL_RST;
      mode_r      <= omsc_pkg::MODE_NONE;
      interval_r  <= omsc_pkg::INTERVAL_RST;
      cnt_r       <= '0;
      vcnt_r      <= '0;
      mean_r      <= '0;
      sum_r       <= '0;
      min_r       <= {1'b0, {(S-1){1'b1}}};
      max_r       <= {1'b1, {(S-1){1'b0}}};
      pow_r       <= C'(10);
      ok_r        <= 1'b0;
      hit_r       <= 1'b0;
      final_r     <= 1'b0;
      pidx_r      <= '0;
      mbusy_r     <= 1'b0;
      mdone_r     <= 1'b0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          omsc_pkg::REG_TOTAL:    total_r    <= cfg_wdata;
          omsc_pkg::REG_MODE:     mode_r     <= cfg_wdata[omsc_pkg::MODE_BITS-1:0];
          omsc_pkg::REG_INTERVAL: interval_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (cmd.load) begin
        ok_r  <= !in_data.sample_invalid;
        cnt_r <= cnt_r + 1'b1;
        if (!in_data.sample_invalid) begin
          vcnt_r <= vcnt_r + 1'b1;
          if (smp < min_r) min_r <= smp;
          if (smp > max_r) max_r <= smp;
        end
      end

      if (cmd.mean_upd) begin
        mean_r <= mean_new;
      end

      mdone_r <= mbusy_r && (mcnt_r == MCW'(1));
      if (cmd.mul_start) begin
        mbusy_r <= 1'b1;
        mcnt_r  <= MCW'(D);
      end else if (mbusy_r) begin
        mcnt_r <= mcnt_r - 1'b1;
        if (mcnt_r == MCW'(1)) mbusy_r <= 1'b0;
      end

      if (cmd.acc_upd) begin
        sum_r <= sum_add[SW] ? '1 : sum_add[SW-1:0];
      end

      if (cmd.sched) begin
        hit_r   <= sched_hit;
        final_r <= final_now;
        pidx_r  <= '0;
        if (cnt_r == pow_r) begin
          pow_r <= (pow_x10 <= (C+4)'({C{1'b1}})) ? C'(pow_x10) : '0;
        end
      end

      if (cmd.pct_step) begin
        pidx_r <= pidx_r + 1'b1;
        if (pct_hit) hit_r <= 1'b1;
      end

      if (cmd.mod_done && (div_rem == '0)) begin
        hit_r <= 1'b1;
      end

      // a new record may be loaded in the cycle the previous one is taken
      out_valid_r <= cmd.emit_cp || cmd.emit_fin || (out_valid_r && !out_ready);

      // the summary clears the run once its record is latched
      if (cmd.emit_fin) begin
        cnt_r  <= '0;
        vcnt_r <= '0;
        mean_r <= '0;
        sum_r  <= '0;
        min_r  <= {1'b0, {(S-1){1'b1}}};
        max_r  <= {1'b1, {(S-1){1'b0}}};
        pow_r  <= C'(10);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r     <= smp;
      delta_r <= delta_in;
    end
    if (cmd.mul_start) begin
      mul_a_r <= abs_delta;
      p_r     <= {{D{1'b0}}, abs_delta2};
    end else if (mbusy_r) begin
      p_r <= {mul_upper, p_r[D-1:1]};
    end
    if (cmd.sd_zero) begin
      sd_r <= '0;
    end else if (cmd.sd_ld) begin
      sd_r <= S'(sq_root);
    end
    if (cmd.emit_cp || cmd.emit_fin) begin
      out_data_r <= rec;
    end
  end

  always_comb begin
    stat.sample_ok   = ok_r;
    stat.n_zero      = (vcnt_r == '0);
    stat.div_done    = div_done;
    stat.mul_done    = mdone_r;
    stat.sqrt_done   = sq_done;
    stat.smart       = (mode_r == omsc_pkg::MODE_SMART);
    stat.mod_need    = (mode_r == omsc_pkg::MODE_INTERVAL) && (interval_r != '0) &&
                       (cnt_r <= limit);
    stat.pct_last    = (pidx_r == omsc_pkg::PCT_IDX_BITS'(omsc_pkg::PCT_N - 1));
    stat.hit         = hit_r;
    stat.final_rec   = final_r;
    stat.multi_valid = (vcnt_r > C'(1));
    stat.out_taken   = out_valid_r && out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/omsc_ctrl.sv =====
// omsc_ctrl: sequencer that steps one transaction through update, schedule and emit
// depends on omsc_pkg for the command and status types
`timescale 1ns / 1ps

module omsc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  omsc_pkg::stat_t  stat,
  output omsc_pkg::cmd_t   cmd
);

  typedef enum logic [16:0] {
    ST_IDLE     = 17'h00001,
    ST_START    = 17'h00002,
    ST_DIVM     = 17'h00004,
    ST_MEAN     = 17'h00008,
    ST_MULS     = 17'h00010,
    ST_MUL      = 17'h00020,
    ST_ACC      = 17'h00040,
    ST_SCHED    = 17'h00080,
    ST_CHECK    = 17'h00100,
    ST_PCT      = 17'h00200,
    ST_MOD      = 17'h00400,
    ST_SD       = 17'h00800,
    ST_DIVSD    = 17'h01000,
    ST_SQRT     = 17'h02000,
    ST_EMIT     = 17'h04000,
    ST_WAIT_CP  = 17'h08000,
    ST_WAIT_FIN = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_op = omsc_pkg::DIV_MEAN;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (!stat.sample_ok) begin
          state_nxt = ST_SCHED;
        end else if (stat.n_zero) begin
          state_nxt = ST_MEAN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = omsc_pkg::DIV_MEAN;
          state_nxt     = ST_DIVM;
        end
      end
      ST_DIVM: if (stat.div_done) state_nxt = ST_MEAN;
      ST_MEAN: begin
        cmd.mean_upd = 1'b1;
        state_nxt    = ST_MULS;
      end
      ST_MULS: begin
        cmd.mul_start = 1'b1;
        state_nxt     = ST_MUL;
      end
      ST_MUL: if (stat.mul_done) state_nxt = ST_ACC;
      ST_ACC: begin
        cmd.acc_upd = 1'b1;
        state_nxt   = ST_SCHED;
      end
      ST_SCHED: begin
        cmd.sched = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.smart) begin
          state_nxt = ST_PCT;
        end else if (stat.mod_need) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = omsc_pkg::DIV_MOD;
          state_nxt     = ST_MOD;
        end else begin
          state_nxt = ST_SD;
        end
      end
      ST_PCT: begin
        cmd.pct_step = 1'b1;
        if (stat.pct_last) state_nxt = ST_SD;
      end
      ST_MOD: begin
        if (stat.div_done) begin
          cmd.mod_done = 1'b1;
          state_nxt    = ST_SD;
        end
      end
      ST_SD: begin
        if (!(stat.hit || stat.final_rec)) begin
          state_nxt = ST_IDLE;
        end else if (stat.multi_valid) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = omsc_pkg::DIV_SD;
          state_nxt     = ST_DIVSD;
        end else begin
          cmd.sd_zero = 1'b1;
          state_nxt   = ST_EMIT;
        end
      end
      ST_DIVSD: begin
        if (stat.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (stat.sqrt_done) begin
          cmd.sd_ld = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.hit) begin
          cmd.emit_cp = 1'b1;
          state_nxt   = ST_WAIT_CP;
        end else begin
          cmd.emit_fin = 1'b1;
          state_nxt    = ST_WAIT_FIN;
        end
      end
      ST_WAIT_CP: begin
        if (stat.out_taken) begin
          if (stat.final_rec) begin
            cmd.emit_fin = 1'b1;
            state_nxt    = ST_WAIT_FIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_WAIT_FIN: if (stat.out_taken) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== dv/online_mean_stddev_checkpoints_core_tb.sv =====
// online_mean_stddev_checkpoints_core_tb: self-checking bench for the online mean/stddev core
// depends on omsc_pkg and online_mean_stddev_checkpoints_core; predicts every record in-bench
`timescale 1ns / 1ps

module online_mean_stddev_checkpoints_core_tb;

  localparam longint CNT_MASK = (64'd1 << omsc_pkg::COUNT_BITS) - 1;
  localparam longint SMP_MAX  = (64'sd1 <<< (omsc_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     SETTLE_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [omsc_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [omsc_pkg::CFG_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  omsc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  omsc_pkg::out_t out_data;

  online_mean_stddev_checkpoints_core DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state and register shadows
  longint unsigned total_reg, mode_reg, interval_reg;
  longint unsigned n_samples, n_valid, sq_sum, next_pow10;
  longint          mean_acc, min_acc, max_acc;

  omsc_pkg::out_t expected_records[$];
  int     errors = 0;
  longint cycles = 0;
  int     sent_items = 0;
  int     records_seen = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic void clear_run();
    n_samples = 0;
    n_valid = 0;
    mean_acc = 0;
    sq_sum = 0;
    min_acc = SMP_MAX;
    max_acc = -SMP_MAX - 1;
    next_pow10 = 10;
  endfunction

  function automatic void queue_record(omsc_pkg::out_t r);
    expected_records.insert(expected_records.size(), r);
  endfunction

  function automatic omsc_pkg::out_t build_record(bit kind, bit last);
    omsc_pkg::out_t r;
    longint unsigned sd;
    bit none;
    none = (n_valid == 0);
    sd = 0;
    if (n_valid > 1) sd = int_sqrt(sq_sum / (n_valid - 1));
    r = '0;
    r.record_kind = kind;
    r.sample_count = n_samples[omsc_pkg::COUNT_BITS-1:0];
    r.valid_count = n_valid[omsc_pkg::COUNT_BITS-1:0];
    r.mean_value = none ? '0 : mean_acc[omsc_pkg::SAMPLE_BITS-1:0];
    r.std_deviation = none ? '0 : sd[omsc_pkg::SAMPLE_BITS-1:0];
    r.minimum = (none || !kind) ? '0 : min_acc[omsc_pkg::SAMPLE_BITS-1:0];
    r.maximum = (none || !kind) ? '0 : max_acc[omsc_pkg::SAMPLE_BITS-1:0];
    r.no_valid = none;
    r.last_result = last;
    return r;
  endfunction

  function automatic void predict_sample(omsc_pkg::in_t s);
    longint v, d1, d2;
    longint unsigned lim, c, nv, a, b, prod, q;
    longint unsigned pcts[8];
    bit hit, fin;
    pcts = '{1, 5, 10, 25, 50, 75, 90, 95};
    v = longint'(s.sample_value);
    lim = (total_reg > CNT_MASK) ? CNT_MASK : total_reg;
    c = (n_samples + 1) & CNT_MASK;
    hit = 0;
    if (!s.sample_invalid) begin
      nv = (n_valid + 1) & CNT_MASK;
      d1 = v - mean_acc;
      if (nv != 0) mean_acc += d1 / longint'(nv);
      d2 = v - mean_acc;
      a = mag(d1);
      b = mag(d2);
      if (a != 0 && b > 64'hFFFF_FFFF_FFFF_FFFF / a) prod = 64'hFFFF_FFFF_FFFF_FFFF;
      else prod = a * b;
      if (sq_sum > 64'hFFFF_FFFF_FFFF_FFFF - prod) sq_sum = 64'hFFFF_FFFF_FFFF_FFFF;
      else sq_sum += prod;
      if (v < min_acc) min_acc = v;
      if (v > max_acc) max_acc = v;
      n_valid = nv;
    end
    n_samples = c;
    if (mode_reg == omsc_pkg::MODE_INTERVAL) begin
      hit = (c == lim);
      if (interval_reg != 0 && c <= lim && (c % interval_reg) == 0) hit = 1;
    end else if (mode_reg == omsc_pkg::MODE_SMART) begin
      hit = (c == lim);
      if (c == next_pow10 && c < lim) hit = 1;
      foreach (pcts[i]) begin
        q = (lim * pcts[i]) / 100;
        if (q > 0 && c == q) hit = 1;
      end
    end
    if (c == next_pow10) next_pow10 = (next_pow10 * 10 <= CNT_MASK) ? next_pow10 * 10 : 0;
    fin = (c >= lim);
    if (hit) queue_record(build_record(1'b0, !fin));
    if (fin) begin
      queue_record(build_record(1'b1, 1'b1));
      clear_run();
    end
  endfunction

  // one transaction on the input channel, idling at the current rate
  // valid stays high after the accept until the next call or a drain takes it down
  task automatic send_sample(logic signed [omsc_pkg::SAMPLE_BITS-1:0] val, logic inv);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{sample_value: val, sample_invalid: inv};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sample('{sample_value: val, sample_invalid: inv});
    sent_items++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      records_seen++;
      if (expected_records.size() == 0) begin
        $display("%0t: unexpected record %p", $time, out_data);
        errors++;
      end else begin
        omsc_pkg::out_t e;
        e = expected_records.pop_front();
        if (e !== out_data) begin
          $display("%0t: record mismatch expected %p actual %p", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(omsc_pkg::reg_idx_t idx, longint unsigned val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[omsc_pkg::CFG_BITS-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      omsc_pkg::REG_TOTAL:    total_reg = val & CNT_MASK;
      omsc_pkg::REG_MODE:     mode_reg = val & 3;
      default:                interval_reg = val & CNT_MASK;
    endcase
  endtask

  task automatic setup_run(longint unsigned total, longint unsigned mode,
                           longint unsigned intv);
    drain();
    write_reg(omsc_pkg::REG_TOTAL, total);
    write_reg(omsc_pkg::REG_MODE, mode);
    write_reg(omsc_pkg::REG_INTERVAL, intv);
  endtask

  function automatic logic signed [omsc_pkg::SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(4, 0))
      0: return $urandom();
      1: return $urandom_range(1, 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(32'h0010_0000, 0)) - 32'sh0008_0000;
    endcase
  endfunction

  task automatic test_directed_extremes();
    setup_run(6, omsc_pkg::MODE_INTERVAL, 2);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh0, 1'b1);
    send_sample(32'shFFFF_FFFF, 1'b1);
    send_sample(32'sh8000_0000, 1'b0);
    // run of only invalid samples, unused mode
    setup_run(3, 3, 1);
    repeat (3) send_sample(32'sh1234_5678, 1'b1);
    // zero interval, then a single valid sample
    setup_run(2, omsc_pkg::MODE_INTERVAL, 0);
    send_sample(32'sh0001_0000, 1'b0);
    send_sample(32'sh0, 1'b1);
    setup_run(1, omsc_pkg::MODE_SMART, 1);
    send_sample(32'sh0002_8000, 1'b0);
    // zero total gives a summary on every sample
    setup_run(0, omsc_pkg::MODE_NONE, 5);
    send_sample(32'sh0000_0001, 1'b0);
    send_sample(32'shFFFF_0000, 1'b0);
    // lowered total in mid-run
    setup_run(10, omsc_pkg::MODE_SMART, 100);
    repeat (4) send_sample(rand_sample(), 1'b0);
    drain();
    write_reg(omsc_pkg::REG_TOTAL, 3);
    send_sample(32'sh5, 1'b0);
  endtask

  task automatic test_random_runs(int items);
    longint unsigned tot;
    int n;
    n = 0;
    while (n < items) begin
      tot = $urandom_range(9, 0) == 0 ? $urandom_range(200, 100) : $urandom_range(40, 1);
      setup_run(tot, $urandom_range(3, 0), $urandom_range(9, 0) == 0 ?
                CNT_MASK : $urandom_range(12, 0));
      repeat (tot) begin
        send_sample(rand_sample(), $urandom_range(5, 0) == 0);
        n++;
      end
    end
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random_runs(250);
    send_idle_pct = 79; recv_stall_pct = 0;  test_random_runs(250);
    send_idle_pct = 0;  recv_stall_pct = 79; test_random_runs(250);
    send_idle_pct = 9;  recv_stall_pct = 9;  test_random_runs(250);
  endtask

  task automatic test_large_total_smart();
    // powers of ten and percent points on a bigger run, then the largest total
    send_idle_pct = 0; recv_stall_pct = 0;
    setup_run(120, omsc_pkg::MODE_SMART, 1);
    repeat (120) send_sample(rand_sample(), $urandom_range(7, 0) == 0);
    setup_run(CNT_MASK, omsc_pkg::MODE_SMART, CNT_MASK);
    repeat (12) send_sample(rand_sample(), 1'b0);
    setup_run(CNT_MASK, omsc_pkg::MODE_INTERVAL, 3);
    repeat (7) send_sample(rand_sample(), 1'b0);
  endtask

  initial begin
    total_reg = 1000;
    mode_reg = omsc_pkg::MODE_NONE;
    interval_reg = 100;
    clear_run();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // reset values: mode none, so nothing until the default total
    repeat (5) send_sample(rand_sample(), 1'b0);
    test_directed_extremes();
    test_idle_phases();
    test_large_total_smart();
    drain();
    $display("sent %0d samples, checked %0d records over all modes and idle phases",
             sent_items, records_seen);
    if (errors == 0 && expected_records.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/omsc_pkg.sv
rtl/core/omsc_div.sv
rtl/core/omsc_sqrt.sv
rtl/core/omsc_dp.sv
rtl/core/omsc_ctrl.sv
rtl/core/online_mean_stddev_checkpoints_core.sv
dv/online_mean_stddev_checkpoints_core_tb.sv
